### rtl/cltc_pkg.sv
package cltc_pkg;

  // capture sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_VS_HIGH,
    PH_VS_LOW,
    PH_HREF_WAIT,
    PH_SKIP,
    PH_CAPTURE
  } phase_e;

  // operation codes of an input item
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_START  = 1'b1;

  // result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // finishing status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd1;
  localparam logic [1:0] STATUS_RANGE   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_CAPTURE_MODE  = 2'd0;
  localparam logic [1:0] REG_TARGET_LINE   = 2'd1;
  localparam logic [1:0] REG_FRAME_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_LINE_TIMEOUT  = 2'd3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int TARGET_W    = 7;
  localparam int TMO_W       = 10;
  localparam int INDEX_W     = 12;
  localparam int ROW_W       = 16;

  localparam logic [TMO_W-1:0] TMO_MAX              = '1;
  localparam logic [ROW_W-1:0] ROW_MAX              = '1;
  localparam logic [TMO_W-1:0] FRAME_TIMEOUT_RESET  = 10'd500;
  localparam logic [TMO_W-1:0] LINE_TIMEOUT_RESET   = 10'd100;

  localparam int IMAGE_WIDTH_DEF     = 160;
  localparam int IMAGE_HEIGHT_DEF    = 120;
  localparam int LINE_BYTES_DEF      = 320;
  localparam int BYTES_PER_PIXEL_DEF = 2;
  localparam int DECIMATION_DEF      = 4;

  typedef struct packed {
    logic               result_kind;
    logic [7:0]         pixel_byte;
    logic [INDEX_W-1:0] byte_index;
    logic [1:0]         status;
    logic               last;
  } result_t;

endpackage

### rtl/cltc_out_buf.sv
module cltc_out_buf import cltc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    pop_i,
  output result_t data_o
);

  result_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_pop  = valid_o && pop_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/camera_line_and_thumbnail_capture_top.sv
// Camera line / thumbnail capture. Each input item is either a start request or one oversample
// of the camera pins (vsync, href, pclk, data byte, millisecond tick); the whole sequencer step is
// done in the cycle the item is taken, so one item per clock is sustained while the queue has room. A
// result (pixel byte or the finishing result with its status) leaves through a two-entry output
// queue; input stalls only while both entries still wait to be taken. Register writes are taken
// at any time and act at once.
module camera_line_and_thumbnail_capture_top import cltc_pkg::*; #(
  parameter int IMAGE_WIDTH     = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT    = IMAGE_HEIGHT_DEF,
  parameter int LINE_BYTES      = LINE_BYTES_DEF,
  parameter int BYTES_PER_PIXEL = BYTES_PER_PIXEL_DEF,
  parameter int DECIMATION      = DECIMATION_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   operation_i,
  input  logic                   vsync_level_i,
  input  logic                   href_level_i,
  input  logic                   pclk_level_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   ms_tick_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   result_kind_o,
  output logic [7:0]             pixel_byte_o,
  output logic [INDEX_W-1:0]     byte_index_o,
  output logic [1:0]             status_o,
  output logic                   last_o
);

  localparam int LBC_W          = $clog2(LINE_BYTES + 1);
  localparam int SUB_W          = (BYTES_PER_PIXEL > 1) ? $clog2(BYTES_PER_PIXEL) : 1;
  localparam int DMOD_W         = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam int LAST_THUMB_ROW = ((IMAGE_HEIGHT - 1) / DECIMATION) * DECIMATION;
  localparam int PIX_BYTES      = IMAGE_WIDTH * BYTES_PER_PIXEL;
  localparam logic [SUB_W-1:0]  SUB_LAST  = SUB_W'(BYTES_PER_PIXEL - 1);
  localparam logic [DMOD_W-1:0] DMOD_LAST = DMOD_W'(DECIMATION - 1);

  // configuration
  logic                capture_mode_q;
  logic [TARGET_W-1:0] target_line_q;
  logic [TMO_W-1:0]    frame_timeout_q;
  logic [TMO_W-1:0]    line_timeout_q;

  // sequencer state
  phase_e              phase_q, phase_d;
  logic                pclk_prev_q, pclk_prev_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [DMOD_W-1:0]   rmod_q, rmod_d;
  logic [LBC_W-1:0]    lbc_q, lbc_d;
  logic [SUB_W-1:0]    sub_q, sub_d;
  logic [DMOD_W-1:0]   pmod_q, pmod_d;
  logic [INDEX_W-1:0]  obc_q, obc_d;
  logic [TMO_W-1:0]    tmo_q, tmo_d;

  logic                in_fire;
  logic                buf_ready;
  logic                rise;
  logic                bad_line;
  logic [TMO_W-1:0]    tmo_inc;
  logic [TMO_W-1:0]    limit;
  logic                tmo_over;
  logic                want_row;
  logic [ROW_W-1:0]    row_next;
  logic [DMOD_W-1:0]   rmod_next;
  logic                cap_go;
  logic [LBC_W-1:0]    lbc_cur;
  logic [SUB_W-1:0]    sub_cur;
  logic [DMOD_W-1:0]   pmod_cur;
  logic                do_fin;
  logic                do_emit;
  logic [1:0]          fin_status;
  logic                res_valid;
  result_t             res;
  result_t             out_res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = buf_ready;
  assign in_fire     = in_valid_i && buf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capture_mode_q  <= 1'b0;
      target_line_q   <= '0;
      frame_timeout_q <= FRAME_TIMEOUT_RESET;
      line_timeout_q  <= LINE_TIMEOUT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_CAPTURE_MODE:  capture_mode_q  <= cfg_data_i[0];
        REG_TARGET_LINE:   target_line_q   <= cfg_data_i[TARGET_W-1:0];
        REG_FRAME_TIMEOUT: frame_timeout_q <= cfg_data_i[TMO_W-1:0];
        REG_LINE_TIMEOUT:  line_timeout_q  <= cfg_data_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  assign rise     = pclk_level_i && !pclk_prev_q;
  assign bad_line = !capture_mode_q && (target_line_q >= IMAGE_HEIGHT);
  assign tmo_inc  = (ms_tick_i && (tmo_q != TMO_MAX)) ? tmo_q + TMO_W'(1) : tmo_q;
  assign limit    = (phase_q == PH_HREF_WAIT) ? line_timeout_q : frame_timeout_q;
  assign tmo_over = tmo_inc > limit;
  assign want_row = capture_mode_q ? (rmod_q == '0)
                                   : (row_q == ROW_W'(target_line_q));
  // row counter saturates, the row phase stops with it
  assign row_next  = (row_q != ROW_MAX) ? row_q + ROW_W'(1) : row_q;
  assign rmod_next = (row_q == ROW_MAX) ? rmod_q
                   : ((rmod_q == DMOD_LAST) ? '0 : rmod_q + DMOD_W'(1));

  // next state
  always_comb begin
    phase_d     = phase_q;
    pclk_prev_d = pclk_prev_q;
    row_d       = row_q;
    rmod_d      = rmod_q;
    lbc_d       = lbc_q;
    sub_d       = sub_q;
    pmod_d      = pmod_q;
    obc_d       = obc_q;
    tmo_d       = tmo_q;
    cap_go      = 1'b0;
    lbc_cur     = lbc_q;
    sub_cur     = sub_q;
    pmod_cur    = pmod_q;
    do_fin      = 1'b0;
    do_emit     = 1'b0;
    fin_status  = STATUS_OK;
    if (in_fire) begin
      if (operation_i == OP_START) begin
        row_d  = '0;
        rmod_d = '0;
        lbc_d  = '0;
        sub_d  = '0;
        pmod_d = '0;
        obc_d  = '0;
        tmo_d  = '0;
        if (bad_line) begin
          do_fin     = 1'b1;
          fin_status = STATUS_RANGE;
          phase_d    = PH_IDLE;
        end else begin
          phase_d = PH_VS_HIGH;
        end
      end else begin
        pclk_prev_d = pclk_level_i;
        tmo_d       = tmo_inc;
        case (phase_q)
          PH_VS_HIGH: begin
            if (vsync_level_i) begin
              phase_d = PH_VS_LOW;
            end else if (tmo_over) begin
              do_fin     = 1'b1;
              fin_status = STATUS_TIMEOUT;
            end
          end
          PH_VS_LOW: begin
            if (!vsync_level_i) begin
              row_d   = '0;
              rmod_d  = '0;
              tmo_d   = '0;
              phase_d = PH_HREF_WAIT;
            end else if (tmo_over) begin
              do_fin     = 1'b1;
              fin_status = STATUS_TIMEOUT;
            end
          end
          PH_HREF_WAIT: begin
            if (!href_level_i) begin
              if (tmo_over) begin
                do_fin     = 1'b1;
                fin_status = STATUS_TIMEOUT;
              end
            end else if (want_row) begin
              cap_go   = 1'b1;
              lbc_cur  = '0;
              sub_cur  = '0;
              pmod_cur = '0;
              phase_d  = PH_CAPTURE;
            end else begin
              phase_d = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (!href_level_i) begin
              row_d   = row_next;
              rmod_d  = rmod_next;
              tmo_d   = '0;
              phase_d = PH_HREF_WAIT;
            end
          end
          PH_CAPTURE: cap_go = 1'b1;
          default: ;
        endcase
        if (cap_go) begin
          lbc_d  = lbc_cur;
          sub_d  = sub_cur;
          pmod_d = pmod_cur;
          if (!href_level_i || (lbc_cur >= LINE_BYTES)) begin
            // end of the row
            if (!capture_mode_q || (row_q >= LAST_THUMB_ROW)) begin
              do_fin = 1'b1;
            end else if (!href_level_i) begin
              row_d   = row_next;
              rmod_d  = rmod_next;
              tmo_d   = '0;
              phase_d = PH_HREF_WAIT;
            end else begin
              phase_d = PH_SKIP;
            end
          end else if (rise) begin
            lbc_d = lbc_cur + LBC_W'(1);
            if (sub_cur == SUB_LAST) begin
              sub_d  = '0;
              pmod_d = (pmod_cur == DMOD_LAST) ? '0 : pmod_cur + DMOD_W'(1);
            end else begin
              sub_d = sub_cur + SUB_W'(1);
            end
            if (!capture_mode_q || ((pmod_cur == '0) && (lbc_cur < PIX_BYTES))) begin
              do_emit = 1'b1;
              obc_d   = obc_q + INDEX_W'(1);
            end
          end
        end
        if (do_fin) begin
          phase_d = PH_IDLE;
        end
      end
    end
  end

  // result
  always_comb begin
    res_valid       = do_fin || do_emit;
    res.result_kind = do_fin ? KIND_DONE : KIND_PIXEL;
    res.pixel_byte  = do_emit ? data_byte_i : 8'd0;
    res.byte_index  = (operation_i == OP_START) ? '0 : obc_q;
    res.status      = do_fin ? fin_status : STATUS_OK;
    res.last        = do_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      pclk_prev_q <= 1'b0;
      row_q       <= '0;
      rmod_q      <= '0;
      lbc_q       <= '0;
      sub_q       <= '0;
      pmod_q      <= '0;
      obc_q       <= '0;
      tmo_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      pclk_prev_q <= pclk_prev_d;
      row_q       <= row_d;
      rmod_q      <= rmod_d;
      lbc_q       <= lbc_d;
      sub_q       <= sub_d;
      pmod_q      <= pmod_d;
      obc_q       <= obc_d;
      tmo_q       <= tmo_d;
    end
  end

  cltc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .ready_o     (buf_ready),
    .valid_o     (out_valid_o),
    .pop_i       (out_ready_i),
    .data_o      (out_res)
  );

  assign result_kind_o = out_res.result_kind;
  assign pixel_byte_o  = out_res.pixel_byte;
  assign byte_index_o  = out_res.byte_index;
  assign status_o      = out_res.status;
  assign last_o        = out_res.last;

`ifndef SYNTHESIS
  a_fin_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.last |=> phase_q == PH_IDLE)
    else $error("finishing result left the sequencer busy");

  a_byte_from_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res.last |-> (phase_q == PH_CAPTURE || phase_q == PH_HREF_WAIT))
    else $error("pixel byte emitted outside a captured row");

  a_index_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res.last |=> obc_q == $past(obc_q) + INDEX_W'(1))
    else $error("output byte count did not advance on a pixel transfer");

  a_line_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CAPTURE |-> lbc_q <= LBC_W'(LINE_BYTES))
    else $error("line byte count passed the line size");
`endif

endmodule

### verif/camera_line_and_thumbnail_capture_top_test.sv
`timescale 1ns / 1ps

module camera_line_and_thumbnail_capture_top_test;
  import cltc_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int LAST_THUMB_ROW = ((IMAGE_HEIGHT_DEF - 1) / DECIMATION_DEF) * DECIMATION_DEF;
  localparam int ITEM_BUDGET    = 1900;

  typedef struct packed {
    logic       op;
    logic       vsync;
    logic       href;
    logic       pclk;
    logic [7:0] data;
    logic       tick;
  } pin_item_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic                   operation_i;
  logic                   vsync_level_i;
  logic                   href_level_i;
  logic                   pclk_level_i;
  logic [7:0]             data_byte_i;
  logic                   ms_tick_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   result_kind_o;
  logic [7:0]             pixel_byte_o;
  logic [INDEX_W-1:0]     byte_index_o;
  logic [1:0]             status_o;
  logic                   last_o;

  camera_line_and_thumbnail_capture_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .vsync_level_i (vsync_level_i),
    .href_level_i  (href_level_i),
    .pclk_level_i  (pclk_level_i),
    .data_byte_i   (data_byte_i),
    .ms_tick_i     (ms_tick_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .pixel_byte_o  (pixel_byte_o),
    .byte_index_o  (byte_index_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  pin_item_t pin_items[$];
  result_t   expected_results[$];
  int        item_total     = 0;
  int        mismatch_count = 0;
  int        cfg_writes     = 0;
  int        send_idle_pct  = 0;
  int        stall_pct      = 0;
  logic      in_taken       = 1'b0;

  // capture sequencer copy, reset values
  phase_e             seq_phase      = PH_IDLE;
  logic               pclk_prev      = 1'b0;
  logic [ROW_W-1:0]   row_cnt        = '0;
  logic [8:0]         row_byte_cnt   = '0;
  logic [INDEX_W-1:0] out_byte_cnt   = '0;
  logic [TMO_W-1:0]   tick_cnt       = '0;
  logic               mode_thumb     = 1'b0;
  logic [TARGET_W-1:0] target_row    = '0;
  logic [TMO_W-1:0]   frame_limit_ms = FRAME_TIMEOUT_RESET;
  logic [TMO_W-1:0]   line_limit_ms  = LINE_TIMEOUT_RESET;

  function automatic result_t capture_done(input logic [1:0] st);
    result_t r;
    r.result_kind = KIND_DONE;
    r.pixel_byte  = '0;
    r.byte_index  = out_byte_cnt;
    r.status      = st;
    r.last        = 1'b1;
    seq_phase     = PH_IDLE;
    return r;
  endfunction

  function automatic void next_row();
    if (row_cnt != ROW_MAX) row_cnt = row_cnt + 1'b1;
    tick_cnt  = '0;
    seq_phase = PH_HREF_WAIT;
  endfunction

  function automatic bit capture_step(input pin_item_t it, output result_t res);
    bit               rise;
    bit               in_row;
    bit               wanted;
    logic [TMO_W-1:0] limit;
    int unsigned      pix;
    res = '0;
    if (it.op == OP_START) begin
      row_cnt      = '0;
      row_byte_cnt = '0;
      out_byte_cnt = '0;
      tick_cnt     = '0;
      if (!mode_thumb && target_row >= IMAGE_HEIGHT_DEF) begin
        res = capture_done(STATUS_RANGE);
        return 1'b1;
      end
      seq_phase = PH_VS_HIGH;
      return 1'b0;
    end
    rise      = it.pclk && !pclk_prev;
    pclk_prev = it.pclk;
    limit     = (seq_phase == PH_HREF_WAIT) ? line_limit_ms : frame_limit_ms;
    if (it.tick && tick_cnt != TMO_MAX) tick_cnt = tick_cnt + 1'b1;
    in_row = 1'b0;
    case (seq_phase)
      PH_VS_HIGH: begin
        if (it.vsync) begin
          seq_phase = PH_VS_LOW;
        end else if (tick_cnt > limit) begin
          res = capture_done(STATUS_TIMEOUT);
          return 1'b1;
        end
      end
      PH_VS_LOW: begin
        if (!it.vsync) begin
          row_cnt   = '0;
          tick_cnt  = '0;
          seq_phase = PH_HREF_WAIT;
        end else if (tick_cnt > limit) begin
          res = capture_done(STATUS_TIMEOUT);
          return 1'b1;
        end
      end
      PH_HREF_WAIT: begin
        if (!it.href) begin
          if (tick_cnt > limit) begin
            res = capture_done(STATUS_TIMEOUT);
            return 1'b1;
          end
        end else begin
          wanted = mode_thumb ? (row_cnt % DECIMATION_DEF == 0) : (row_cnt == target_row);
          if (wanted) begin
            row_byte_cnt = '0;
            seq_phase    = PH_CAPTURE;
            in_row       = 1'b1;
          end else begin
            seq_phase = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (!it.href) next_row();
      end
      PH_CAPTURE: begin
        in_row = 1'b1;
      end
      default: ;
    endcase
    if (!in_row) return 1'b0;
    // row over or line full
    if (!it.href || row_byte_cnt >= LINE_BYTES_DEF) begin
      if (!mode_thumb || row_cnt >= LAST_THUMB_ROW) begin
        res = capture_done(STATUS_OK);
        return 1'b1;
      end
      if (!it.href) next_row();
      else seq_phase = PH_SKIP;
      return 1'b0;
    end
    if (!rise) return 1'b0;
    pix          = row_byte_cnt / BYTES_PER_PIXEL_DEF;
    row_byte_cnt = row_byte_cnt + 1'b1;
    if (mode_thumb && (pix % DECIMATION_DEF != 0 || pix >= IMAGE_WIDTH_DEF)) return 1'b0;
    res.result_kind = KIND_PIXEL;
    res.pixel_byte  = it.data;
    res.byte_index  = out_byte_cnt;
    res.status      = STATUS_OK;
    res.last        = 1'b0;
    out_byte_cnt    = out_byte_cnt + 1'b1;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * 400000);
    $display("camera_line_and_thumbnail_capture_top_test: errors");
    $finish;
  end

  always @(negedge clk_i) begin : drive
    pin_item_t nxt;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pin_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pin_items.pop_front();
          in_valid_i    <= 1'b1;
          operation_i   <= nxt.op;
          vsync_level_i <= nxt.vsync;
          href_level_i  <= nxt.href;
          pclk_level_i  <= nxt.pclk;
          data_byte_i   <= nxt.data;
          ms_tick_i     <= nxt.tick;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch
    pin_item_t seen;
    result_t   got;
    result_t   want_r;
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_CAPTURE_MODE:  mode_thumb     = cfg_data_i[0];
          REG_TARGET_LINE:   target_row     = cfg_data_i[TARGET_W-1:0];
          REG_FRAME_TIMEOUT: frame_limit_ms = cfg_data_i;
          REG_LINE_TIMEOUT:  line_limit_ms  = cfg_data_i;
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid_i && in_ready_o) begin
        seen.op    = operation_i;
        seen.vsync = vsync_level_i;
        seen.href  = href_level_i;
        seen.pclk  = pclk_level_i;
        seen.data  = data_byte_i;
        seen.tick  = ms_tick_i;
        if (capture_step(seen, want_r)) expected_results.push_back(want_r);
      end
      if (out_valid_o && out_ready_i) begin
        got.result_kind = result_kind_o;
        got.pixel_byte  = pixel_byte_o;
        got.byte_index  = byte_index_o;
        got.status      = status_o;
        got.last        = last_o;
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected, byte_index", got.byte_index, -1);
        end else begin
          want_r = expected_results.pop_front();
          if (got.result_kind != want_r.result_kind)
            report_mismatch("result_kind", got.result_kind, want_r.result_kind);
          if (got.pixel_byte != want_r.pixel_byte)
            report_mismatch("pixel_byte", got.pixel_byte, want_r.pixel_byte);
          if (got.byte_index != want_r.byte_index)
            report_mismatch("byte_index", got.byte_index, want_r.byte_index);
          if (got.status != want_r.status)
            report_mismatch("status", got.status, want_r.status);
          if (got.last != want_r.last)
            report_mismatch("last", got.last, want_r.last);
        end
      end
    end
  end

  function automatic logic coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic tick_at(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic add_item(input logic op, input logic vs, input logic hr, input logic pc,
                          input logic [7:0] db, input logic tk);
    pin_item_t it;
    it.op    = op;
    it.vsync = vs;
    it.href  = hr;
    it.pclk  = pc;
    it.data  = db;
    it.tick  = tk;
    pin_items.push_back(it);
    item_total++;
  endtask

  task automatic drain_results();
    do @(negedge clk_i);
    while (pin_items.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    int seen_writes;
    seen_writes = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[CFG_DATA_W-1:0];
    do @(negedge clk_i);
    while (cfg_writes == seen_writes);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure_phase(input logic mode, input int target, input int frame_ms,
                                 input int line_ms, input int idle, input int stall);
    drain_results();
    write_reg(REG_CAPTURE_MODE, 32'(mode));
    write_reg(REG_TARGET_LINE, target);
    write_reg(REG_FRAME_TIMEOUT, frame_ms);
    write_reg(REG_LINE_TIMEOUT, line_ms);
    send_idle_pct = idle;
    stall_pct     = stall;
  endtask

  // start, vsync pulse, then rows; heavy rows are the ones the capture keeps
  task automatic gen_frame(input int rows, input int max_rises, input int tick_pct,
                           input bit long_row);
    int rises;
    bit heavy;
    bit stretch;
    stretch = long_row;
    add_item(OP_START, coin(), coin(), coin(), any_byte(), coin());
    repeat ($urandom_range(0, 3))
      add_item(OP_SAMPLE, 1'b0, coin(), coin(), any_byte(), tick_at(tick_pct));
    repeat ($urandom_range(1, 3))
      add_item(OP_SAMPLE, 1'b1, coin(), coin(), any_byte(), tick_at(tick_pct));
    for (int r = 0; r < rows; r++) begin
      if (r == 0) add_item(OP_SAMPLE, 1'b0, 1'b0, coin(), any_byte(), tick_at(tick_pct));
      repeat ($urandom_range(0, 2))
        add_item(OP_SAMPLE, coin(), 1'b0, coin(), any_byte(), tick_at(tick_pct));
      heavy = mode_thumb ? (r % DECIMATION_DEF == 0) : (r == target_row);
      if (!heavy) rises = $urandom_range(0, 1);
      else if (stretch) rises = LINE_BYTES_DEF + 2;
      else rises = $urandom_range(0, max_rises);
      if (heavy) stretch = 1'b0;
      add_item(OP_SAMPLE, coin(), 1'b1, 1'b0, any_byte(), tick_at(tick_pct));
      repeat (rises) begin
        add_item(OP_SAMPLE, coin(), 1'b1, 1'b1, any_byte(), tick_at(tick_pct));
        add_item(OP_SAMPLE, coin(), 1'b1, 1'b0, any_byte(), tick_at(tick_pct));
      end
      add_item(OP_SAMPLE, coin(), 1'b0, coin(), any_byte(), tick_at(tick_pct));
    end
  endtask

  task automatic gen_noise(input int n);
    repeat (n)
      add_item(($urandom_range(0, 15) == 0) ? OP_START : OP_SAMPLE,
               coin(), coin(), coin(), any_byte(), coin());
  endtask

  initial begin : stimulus
    int   round;
    logic thumb;
    int   send;
    int   stall;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    operation_i   = OP_SAMPLE;
    vsync_level_i = 1'b0;
    href_level_i  = 1'b0;
    pclk_level_i  = 1'b0;
    data_byte_i   = '0;
    ms_tick_i     = 1'b0;
    out_ready_i   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: line mode on row 0
    add_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);  // idle, pins only tracked
    add_item(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_item(OP_START,  1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);  // pins ignored on a start
    add_item(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b1);
    add_item(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
    add_item(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_item(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
    add_item(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
    add_item(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 8'hAA, 1'b1);
    add_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 8'hFF, 1'b1);
    add_item(OP_SAMPLE, 1'b0, 1'b0, 1'b1, 8'h55, 1'b0);
    add_item(OP_START,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_item(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
    add_item(OP_START,  1'b0, 1'b0, 1'b0, 8'h00, 1'b0);  // restart drops the running capture
    add_item(OP_SAMPLE, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0);
    add_item(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
    add_item(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 8'h80, 1'b0);  // row entry on a pclk rise
    add_item(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 8'h01, 1'b0);
    gen_frame(2, 6, 0, 1'b0);

    // zero limits, timeouts everywhere
    configure_phase(1'b0, 1, 0, 0, 0, 0);
    repeat (3) gen_frame(3, 4, 30, 1'b0);
    drain_results();
    repeat (3) gen_frame(3, 4, 30, 1'b0);
    gen_noise(40);

    // rows beyond the frame height
    configure_phase(1'b0, 127, 1023, 1023, 48, 0);
    repeat (2) gen_frame(2, 4, 10, 1'b0);
    configure_phase(1'b0, IMAGE_HEIGHT_DEF, 1023, 1023, 48, 0);
    gen_frame(2, 4, 10, 1'b0);
    gen_noise(30);

    // line mode under output stalls
    configure_phase(1'b0, 2, 1023, 1023, 0, 48);
    repeat (3) gen_frame(4, 8, 20, 1'b0);

    // whole thumbnail, first kept row overfull
    configure_phase(1'b1, 127, 1023, 1023, 26, 26);
    gen_frame(LAST_THUMB_ROW + 2, 2, 20, 1'b1);
    gen_noise(30);

    // thumbnail under tight limits
    configure_phase(1'b1, 0, 5, 3, 0, 0);
    repeat (2) gen_frame(10, 6, 15, 1'b0);

    round = 0;
    while (item_total < ITEM_BUDGET || round < 4) begin
      thumb = ($urandom_range(0, 3) == 0);
      case (round % 4)
        0:       begin send = 0;  stall = 0;  end
        1:       begin send = 48; stall = 0;  end
        2:       begin send = 0;  stall = 48; end
        default: begin send = 26; stall = 26; end
      endcase
      configure_phase(thumb, $urandom_range(0, 7), $urandom_range(0, 40),
                      $urandom_range(0, 15), send, stall);
      gen_frame(thumb ? 13 : target_row + 1 + $urandom_range(0, 2), 8, 12, 1'b0);
      gen_noise(25);
      round++;
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("camera_line_and_thumbnail_capture_top_test: clean");
    end else begin
      $display("camera_line_and_thumbnail_capture_top_test: errors");
    end
    $finish;
  end

endmodule
